FILE: design/lookat_view_matrix_top_assert.svh
// Assertion macros shared by the look-at view matrix design.
`ifndef LOOKAT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOKAT_VIEW_MATRIX_TOP_ASSERT_SVH
`ifndef SYNTH
`define LVM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lookat_view_matrix: assertion failed");
`define LVM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lookat_view_matrix: assertion failed");
`else
`define LVM_ASSERT_IMP(lbl, ante, cons)
`define LVM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/lvm_pkg.sv
// Package with widths, types and helper functions of the look-at view matrix design.
package lvm_pkg;
	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int OUT_W = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int IN_W = 32;
	localparam int COL_W = 32;
	localparam int QB = FRAC_BITS + 1;
	localparam int N_W = QB + 1;
	localparam int VEC_W = IN_W + N_W + 1;
	localparam int MAG_W = VEC_W;
	localparam int TOP_W = $clog2(MAG_W);
	localparam int NT = 29;
	localparam int MN_W = NT + 1;
	localparam int SQ_W = 2 * MN_W;
	localparam int RT_W = 64;
	localparam int LEN_W = MN_W + 1;
	localparam int NUM_W = MN_W + FRAC_BITS + 1;
	localparam int SQ_ST = RT_W / 4;
	localparam int DV_ST = (QB + 1) / 2;
	localparam int G_SQ0 = 5;
	localparam int G_DVI = G_SQ0 + SQ_ST;
	localparam int G_DV0 = G_DVI + 1;
	localparam int G_SGN = G_DV0 + DV_ST;
	localparam int NORM_STAGES = G_SGN + 1;
	localparam int Y_W = N_W + 1;
	localparam int S_DATA_W = 9 * IN_W;
	localparam int M_DATA_W = ((2 + 4 * COL_W + 7) / 8) * 8;
	localparam logic [1:0] LAST_ROW = 2'd3;

	typedef struct packed {
		logic [2:0][IN_W-1:0] eye;
		logic [2:0][IN_W-1:0] up;
		logic [2:0][N_W-1:0] z;
		logic deg;
	} side_t;

	function automatic logic [COL_W-1:0] sat_out(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		logic signed [63:0] r;
		hi = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[COL_W-1:0];
	endfunction

	function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] v);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [TOP_W-1:0] msb_idx(input logic [MAG_W-1:0] v);
		logic [TOP_W-1:0] r;
		r = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (v[i]) r = i[TOP_W-1:0];
		end
		return r;
	endfunction
endpackage

FILE: design/lvm_norm.sv
// Pipelined vector normalizer: scale, square sum, integer square root and division.
module lvm_norm (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [2:0][lvm_pkg::VEC_W-1:0] vec,
	input  lvm_pkg::side_t in_side,
	output logic out_valid,
	output logic [2:0][lvm_pkg::N_W-1:0] nrm,
	output logic zero,
	output lvm_pkg::side_t out_side
);
	typedef struct packed {
		logic [2:0] neg;
		logic [2:0][lvm_pkg::MAG_W-1:0] mag;
		logic [lvm_pkg::TOP_W-1:0] top;
		logic [2:0][lvm_pkg::MN_W-1:0] mn;
		logic [2:0][lvm_pkg::SQ_W-1:0] sq;
		logic [lvm_pkg::RT_W-1:0] rv;
		logic [lvm_pkg::RT_W-1:0] rr;
		logic [2:0][lvm_pkg::NUM_W-1:0] num;
		logic [2:0][lvm_pkg::LEN_W-1:0] rem;
		logic [2:0][lvm_pkg::QB-1:0] q;
		logic [2:0][lvm_pkg::N_W-1:0] res;
		logic zero;
		lvm_pkg::side_t side;
	} nst_t;

	localparam int NS = lvm_pkg::NORM_STAGES;

	nst_t nst_q [NS];
	nst_t nx [NS];
	logic [NS-1:0] vld_q;

	for (genvar g = 0; g < NS; g++) begin : g_st
		if (g == 0) begin : g_first
			always_comb begin
				logic signed [lvm_pkg::VEC_W-1:0] v;
				nx[g] = '0;
				for (int i = 0; i < 3; i++) begin
					v = $signed(vec[i]);
					nx[g].neg[i] = v[lvm_pkg::VEC_W-1];
					nx[g].mag[i] = v[lvm_pkg::VEC_W-1] ? -v : v;
				end
				nx[g].zero = (nx[g].mag[0] | nx[g].mag[1] | nx[g].mag[2]) == '0;
				nx[g].side = in_side;
			end
		end else begin : g_rest
			always_comb begin
				logic [lvm_pkg::MAG_W-1:0] sh;
				logic [lvm_pkg::RT_W-1:0] b;
				logic [lvm_pkg::LEN_W-1:0] len;
				logic [lvm_pkg::LEN_W:0] tt;
				int k;
				nx[g] = nst_q[g-1];
				sh = '0;
				b = '0;
				len = nx[g].rr[lvm_pkg::LEN_W-1:0];
				tt = '0;
				k = 0;
				if (g == 1) begin
					nx[g].top = lvm_pkg::msb_idx(nx[g].mag[0] | nx[g].mag[1] | nx[g].mag[2]);
				end else if (g == 2) begin
					for (int i = 0; i < 3; i++) begin
						if (int'(nx[g].top) > lvm_pkg::NT) begin
							sh = nx[g].mag[i] >> (int'(nx[g].top) - lvm_pkg::NT);
						end else begin
							sh = nx[g].mag[i] << (lvm_pkg::NT - int'(nx[g].top));
						end
						nx[g].mn[i] = sh[lvm_pkg::MN_W-1:0];
					end
				end else if (g == 3) begin
					for (int i = 0; i < 3; i++) begin
						nx[g].sq[i] = nx[g].mn[i] * nx[g].mn[i];
					end
				end else if (g == 4) begin
					nx[g].rv = '0;
					for (int i = 0; i < 3; i++) begin
						nx[g].rv = nx[g].rv
							+ {{(lvm_pkg::RT_W-lvm_pkg::SQ_W){1'b0}}, nx[g].sq[i]};
					end
					nx[g].rr = '0;
				end else if (g < lvm_pkg::G_DVI) begin
					for (int t = 0; t < 2; t++) begin
						k = 2 * (g - lvm_pkg::G_SQ0) + t;
						b = '0;
						b[lvm_pkg::RT_W-2-2*k] = 1'b1;
						if (nx[g].rv >= nx[g].rr + b) begin
							nx[g].rv = nx[g].rv - (nx[g].rr + b);
							nx[g].rr = (nx[g].rr >> 1) + b;
						end else begin
							nx[g].rr = nx[g].rr >> 1;
						end
					end
				end else if (g == lvm_pkg::G_DVI) begin
					for (int i = 0; i < 3; i++) begin
						nx[g].num[i] = {1'b0, nx[g].mn[i], {lvm_pkg::FRAC_BITS{1'b0}}}
							+ {{(lvm_pkg::NUM_W-lvm_pkg::LEN_W){1'b0}}, len >> 1};
						nx[g].rem[i] = {{(lvm_pkg::LEN_W-lvm_pkg::NUM_W+lvm_pkg::QB){1'b0}},
							nx[g].num[i][lvm_pkg::NUM_W-1:lvm_pkg::QB]};
						nx[g].q[i] = '0;
					end
				end else if (g < lvm_pkg::G_SGN) begin
					for (int t = 0; t < 2; t++) begin
						k = 2 * (g - lvm_pkg::G_DV0) + t;
						if (k < lvm_pkg::QB) begin
							for (int i = 0; i < 3; i++) begin
								tt = {nx[g].rem[i], nx[g].num[i][lvm_pkg::QB-1-k]};
								if (tt >= {1'b0, len}) begin
									tt = tt - {1'b0, len};
									nx[g].q[i][lvm_pkg::QB-1-k] = 1'b1;
								end
								nx[g].rem[i] = tt[lvm_pkg::LEN_W-1:0];
							end
						end
					end
				end else begin
					for (int i = 0; i < 3; i++) begin
						nx[g].res[i] = nx[g].neg[i] ? -{1'b0, nx[g].q[i]} : {1'b0, nx[g].q[i]};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < NS; g++) begin
				nst_q[g] <= nx[g];
			end
		end
	end

	assign out_valid = vld_q[NS-1];
	assign nrm = nst_q[NS-1].res;
	assign zero = nst_q[NS-1].zero;
	assign out_side = nst_q[NS-1].side;
endmodule

FILE: design/lookat_view_matrix_top.sv
// Top level of the look-at view matrix builder.
// Input channel s_*: one request carries eye, target and up vectors, nine signed
// Q16.16 words, accepted when s_tvalid and s_tready are both high.
// Output channel m_*: each request yields four rows of the view matrix, one per
// handshake, row 0 first; m_tlast marks row 3 and m_tuser flags a zero-length
// vector, in which case every column is zero.
// The datapath is a 71-stage pipeline followed by a row buffer: two normalizer
// pipelines of 32 stages each (square root two bits per stage, division two
// quotient bits per stage) and cross and dot product stages. The first row
// appears once the request has passed the pipeline and the row buffer, the
// following rows one per handshake. The pipeline takes new requests while rows
// are sent; throughput is set by the four output rows. Reset clears all valid
// bits, the busy flag and the row index; no request is in flight. When the
// receiver stalls, the row buffer holds its row and the pipeline freezes once its
// last stage holds a finished matrix; s_tready then falls, nothing lost or repeated.
module lookat_view_matrix_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
	input  logic [lvm_pkg::S_DATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// row_index, col0, col1, col2, col3, zero padding
	output logic [lvm_pkg::M_DATA_W-1:0] m_tdata,
	output logic m_tlast,
	// degenerate
	output logic m_tuser
);
	localparam int IW = lvm_pkg::IN_W;
	localparam int NW = lvm_pkg::N_W;
	localparam int PW = lvm_pkg::IN_W + lvm_pkg::N_W;
	localparam int YPW = 2 * lvm_pkg::N_W;
	localparam int EYW = lvm_pkg::Y_W + lvm_pkg::IN_W;
	localparam int CW = lvm_pkg::COL_W;

	logic adv;
	logic load;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic [2:0][lvm_pkg::VEC_W-1:0] d_s1, c_s3;
	lvm_pkg::side_t side_s1, side_s2, side_s3;
	logic [5:0][PW-1:0] cp_s2;

	logic n1_valid, n1_zero, n2_valid, n2_zero;
	logic [2:0][NW-1:0] n1_n, n2_n;
	lvm_pkg::side_t n1_side, n2_side;

	logic [2:0][NW-1:0] x_s4, z_s4, x_s5, z_s5, x_s6, z_s6;
	logic [2:0][IW-1:0] eye_s4, eye_s5;
	logic [5:0][YPW-1:0] yp_s4;
	logic [2:0][PW-1:0] ex_s4, ez_s4;
	logic deg_s4, deg_s5, deg_s6, deg_s7;
	logic [2:0][lvm_pkg::Y_W-1:0] y_s5, y_s6;
	logic signed [63:0] dx_s5, dz_s5, dx_s6, dz_s6;
	logic [2:0][EYW-1:0] ey_s6;
	logic [3:0][3:0][CW-1:0] mat_s7, mat_q;

	logic busy_q, deg_q;
	logic [1:0] row_q;

	assign load = valid_s7 && (!busy_q || (m_tready && row_q == lvm_pkg::LAST_ROW));
	assign adv = !valid_s7 || load;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= n1_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= n2_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= $signed(s_tdata[i*IW +: IW]) - $signed(s_tdata[(i+3)*IW +: IW]);
			end
			side_s1.eye <= s_tdata[3*IW-1:0];
			side_s1.up <= s_tdata[9*IW-1:6*IW];
			side_s1.z <= '0;
			side_s1.deg <= 1'b0;

			cp_s2[0] <= $signed(n1_side.up[1]) * $signed(n1_n[2]);
			cp_s2[1] <= $signed(n1_side.up[2]) * $signed(n1_n[1]);
			cp_s2[2] <= $signed(n1_side.up[2]) * $signed(n1_n[0]);
			cp_s2[3] <= $signed(n1_side.up[0]) * $signed(n1_n[2]);
			cp_s2[4] <= $signed(n1_side.up[0]) * $signed(n1_n[1]);
			cp_s2[5] <= $signed(n1_side.up[1]) * $signed(n1_n[0]);
			side_s2.eye <= n1_side.eye;
			side_s2.up <= n1_side.up;
			side_s2.z <= n1_n;
			side_s2.deg <= n1_zero;

			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= $signed(cp_s2[2*i]) - $signed(cp_s2[2*i+1]);
			end
			side_s3 <= side_s2;

			x_s4 <= n2_n;
			z_s4 <= n2_side.z;
			eye_s4 <= n2_side.eye;
			deg_s4 <= n2_side.deg || n2_zero;
			yp_s4[0] <= $signed(n2_side.z[1]) * $signed(n2_n[2]);
			yp_s4[1] <= $signed(n2_side.z[2]) * $signed(n2_n[1]);
			yp_s4[2] <= $signed(n2_side.z[2]) * $signed(n2_n[0]);
			yp_s4[3] <= $signed(n2_side.z[0]) * $signed(n2_n[2]);
			yp_s4[4] <= $signed(n2_side.z[0]) * $signed(n2_n[1]);
			yp_s4[5] <= $signed(n2_side.z[1]) * $signed(n2_n[0]);
			for (int i = 0; i < 3; i++) begin
				ex_s4[i] <= $signed(n2_n[i]) * $signed(n2_side.eye[i]);
				ez_s4[i] <= $signed(n2_side.z[i]) * $signed(n2_side.eye[i]);
			end
		end
	end

	// Round y and the x and z dot products with the eye point, then multiply y by the eye point.
	always_ff @(posedge clk) begin
		logic signed [63:0] t;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				t = $signed(yp_s4[2*i]) - $signed(yp_s4[2*i+1]);
				t = lvm_pkg::shr_rnd(t);
				y_s5[i] <= t[lvm_pkg::Y_W-1:0];
			end
			t = $signed(ex_s4[0]) + $signed(ex_s4[1]) + $signed(ex_s4[2]);
			dx_s5 <= -lvm_pkg::shr_rnd(t);
			t = $signed(ez_s4[0]) + $signed(ez_s4[1]) + $signed(ez_s4[2]);
			dz_s5 <= -lvm_pkg::shr_rnd(t);
			x_s5 <= x_s4;
			z_s5 <= z_s4;
			eye_s5 <= eye_s4;
			deg_s5 <= deg_s4;

			for (int i = 0; i < 3; i++) begin
				ey_s6[i] <= $signed(y_s5[i]) * $signed(eye_s5[i]);
			end
			x_s6 <= x_s5;
			y_s6 <= y_s5;
			z_s6 <= z_s5;
			dx_s6 <= dx_s5;
			dz_s6 <= dz_s5;
			deg_s6 <= deg_s5;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] t;
		if (adv) begin
			t = $signed(ey_s6[0]) + $signed(ey_s6[1]) + $signed(ey_s6[2]);
			t = -lvm_pkg::shr_rnd(t);
			for (int i = 0; i < 3; i++) begin
				mat_s7[i][0] <= deg_s6 ? '0 : lvm_pkg::sat_out($signed(x_s6[i]));
				mat_s7[i][1] <= deg_s6 ? '0 : lvm_pkg::sat_out($signed(y_s6[i]));
				mat_s7[i][2] <= deg_s6 ? '0 : lvm_pkg::sat_out($signed(z_s6[i]));
				mat_s7[i][3] <= '0;
			end
			mat_s7[3][0] <= deg_s6 ? '0 : lvm_pkg::sat_out(dx_s6);
			mat_s7[3][1] <= deg_s6 ? '0 : lvm_pkg::sat_out(t);
			mat_s7[3][2] <= deg_s6 ? '0 : lvm_pkg::sat_out(dz_s6);
			mat_s7[3][3] <= deg_s6 ? '0 : lvm_pkg::sat_out(64'sd1 <<< lvm_pkg::FRAC_BITS);
			deg_s7 <= deg_s6;
		end
	end

	lvm_norm u_norm_z (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(valid_s1),
		.vec(d_s1),
		.in_side(side_s1),
		.out_valid(n1_valid),
		.nrm(n1_n),
		.zero(n1_zero),
		.out_side(n1_side)
	);

	lvm_norm u_norm_x (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(valid_s3),
		.vec(c_s3),
		.in_side(side_s3),
		.out_valid(n2_valid),
		.nrm(n2_n),
		.zero(n2_zero),
		.out_side(n2_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q <= '0;
		end else if (busy_q && m_tready) begin
			if (row_q == lvm_pkg::LAST_ROW) begin
				busy_q <= 1'b0;
			end
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mat_q <= mat_s7;
			deg_q <= deg_s7;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata = {{(lvm_pkg::M_DATA_W-2-4*CW){1'b0}},
		mat_q[row_q][3], mat_q[row_q][2], mat_q[row_q][1], mat_q[row_q][0], row_q};
	assign m_tlast = row_q == lvm_pkg::LAST_ROW;
	assign m_tuser = deg_q;

`include "lookat_view_matrix_top_assert.svh"

	`LVM_ASSERT_NXT(a_row_hold, m_tvalid && !m_tready, m_tvalid && $stable(row_q))
	`LVM_ASSERT_NXT(a_no_gap, m_tvalid && m_tready && row_q != lvm_pkg::LAST_ROW, m_tvalid)
	`LVM_ASSERT_NXT(a_s7_hold, valid_s7 && !adv, valid_s7)
	`LVM_ASSERT_IMP(a_ready_free, !busy_q, s_tready)
endmodule
